FILE: src/crfr_pkg.sv
// Shared types, constants and the CRC byte step for the CRC-16 frame receiver.
// Used by the microcode ROM, the sequencer, the datapath and the top level.
// No dependencies.
package crfr_pkg;

   // Frame geometry
   localparam int DETECT_FRAME_BYTES = 9;
   localparam int NUMBER_FRAME_BYTES = 8;
   localparam int WIN_IDX_W          = $clog2(DETECT_FRAME_BYTES);
   localparam int FILL_W             = 4;
   localparam int PAYLOAD_BYTES      = 6;

   // CRC-16, reflected, poly 0x8408, init 0xFFFF, no final xor
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   // Header reset values
   localparam logic [7:0] DETECT_HEADER_RST = 8'hAA;
   localparam logic [7:0] NUMBER_HEADER_RST = 8'hCC;

   // Register indexes on the csr port
   localparam int          CSR_IDX_W         = 8;
   localparam logic [7:0]  CSR_DETECT_HEADER = 8'd0;
   localparam logic [7:0]  CSR_NUMBER_HEADER = 8'd1;

   // Frame kind codes
   localparam logic KIND_DETECT = 1'b0;
   localparam logic KIND_NUMBER = 1'b1;

   // Microprogram
   localparam int UCODE_STEPS = 10;
   localparam int PC_W        = $clog2(UCODE_STEPS);

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [1:0] {
      JMP_NEXT = 2'd0,   // fall through to pc + 1
      JMP_BYTE = 2'd1,   // advance on a byte that leaves at least eight bytes in the window, else jump
      JMP_EMIT = 2'd2    // hold while a hit waits for the output, else jump
   } jump_type;

   typedef struct packed {
      logic     in_ready;
      logic     crc_init;
      logic     crc_d_en;
      logic     crc_n_en;
      logic     rotate;
      logic     check;
      jump_type cond;
      pc_type   target;
   } ucode_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic byte_beat;
      logic fill_long;
      logic hit;
      logic out_free;
   } dp_status_type;

   // One byte through the reflected CRC
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: src/crfr_ucode_rom.sv
// Microcode ROM: one control word per sequencer step.
// Depends on crfr_pkg.
module crfr_ucode_rom (
   input  crfr_pkg::pc_type    pc,
   output crfr_pkg::ucode_type word
);

   // Step 0 waits for a byte, steps 1..9 rotate the window once around,
   // running the two CRCs on the way, and step 9 decides.
   always_comb begin
      word = '0;
      case (pc)
         crfr_pkg::pc_type'(0): begin
            word.in_ready = 1'b1;
            word.crc_init = 1'b1;
            word.cond     = crfr_pkg::JMP_BYTE;
            word.target   = crfr_pkg::pc_type'(0);
         end
         crfr_pkg::pc_type'(1), crfr_pkg::pc_type'(2), crfr_pkg::pc_type'(3),
         crfr_pkg::pc_type'(4), crfr_pkg::pc_type'(5), crfr_pkg::pc_type'(6): begin
            word.crc_d_en = 1'b1;
            word.crc_n_en = 1'b1;
            word.rotate   = 1'b1;
            word.cond     = crfr_pkg::JMP_NEXT;
         end
         crfr_pkg::pc_type'(7): begin
            word.crc_d_en = 1'b1;
            word.rotate   = 1'b1;
            word.cond     = crfr_pkg::JMP_NEXT;
         end
         crfr_pkg::pc_type'(8): begin
            word.rotate = 1'b1;
            word.cond   = crfr_pkg::JMP_NEXT;
         end
         crfr_pkg::pc_type'(9): begin
            word.rotate = 1'b1;
            word.check  = 1'b1;
            word.cond   = crfr_pkg::JMP_EMIT;
            word.target = crfr_pkg::pc_type'(0);
         end
         default: begin
            // unused steps fall back to the wait word
            word.in_ready = 1'b1;
            word.crc_init = 1'b1;
            word.cond     = crfr_pkg::JMP_BYTE;
            word.target   = crfr_pkg::pc_type'(0);
         end
      endcase
   end

endmodule

FILE: src/crfr_seq.sv
// Sequencer: step counter, microcode fetch and conditional jumps.
// Depends on crfr_pkg and crfr_ucode_rom.
module crfr_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  crfr_pkg::dp_status_type status,
   output crfr_pkg::ucode_type     ctl,
   output logic                    go
);

   crfr_pkg::pc_type pc_ff, pc_in;

   crfr_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (ctl)
   );

   // Stall only when a found frame cannot be handed to the output yet
   assign go = !((ctl.cond == crfr_pkg::JMP_EMIT) && status.hit && !status.out_free);

   // Next step
   always_comb begin
      case (ctl.cond)
         crfr_pkg::JMP_NEXT: pc_in = pc_ff + crfr_pkg::pc_type'(1);
         crfr_pkg::JMP_BYTE: pc_in = (status.byte_beat && status.fill_long) ?
                                     pc_ff + crfr_pkg::pc_type'(1) : ctl.target;
         crfr_pkg::JMP_EMIT: pc_in = go ? ctl.target : pc_ff;
         default:            pc_in = ctl.target;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

FILE: src/crfr_datapath.sv
// Datapath: header registers, byte window, two CRC accumulators, frame
// compare and the output register. Driven by the sequencer's control word.
// Depends on crfr_pkg.
module crfr_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  crfr_pkg::ucode_type     ctl,
   input  logic                    go,
   output crfr_pkg::dp_status_type status,
   input  logic                    req_tvalid,
   input  logic [7:0]              req_tdata,
   input  logic                    csr_valid,
   input  logic [crfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]              csr_data,
   input  logic                    rsp_tready,
   output logic                    rsp_tvalid,
   output logic [47:0]             rsp_tdata,
   output logic                    rsp_tuser
);

   localparam int NB = crfr_pkg::DETECT_FRAME_BYTES;

   logic [7:0] det_hdr_ff, det_hdr_in;
   logic [7:0] num_hdr_ff, num_hdr_in;
   logic [7:0] win_ff [NB];
   logic [7:0] win_in [NB];
   logic [crfr_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [15:0] crc_d_ff, crc_d_in, crc_n_ff, crc_n_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_kind_ff, rsp_kind_in;

   logic        byte_beat, full, nb_sel, det_ok, num_ok, hit, load, out_free;
   logic [7:0]  n_tap, n_hdr, n_lo, n_hi;
   logic [47:0] det_pl, num_pl;

   // Config writes
   always_comb begin
      det_hdr_in = det_hdr_ff;
      num_hdr_in = num_hdr_ff;
      if (csr_valid) begin
         case (csr_index)
            crfr_pkg::CSR_DETECT_HEADER: det_hdr_in = csr_data;
            crfr_pkg::CSR_NUMBER_HEADER: num_hdr_in = csr_data;
            default: ;
         endcase
      end
   end

   assign byte_beat = req_tvalid && ctl.in_ready;
   assign full      = (fill_ff == crfr_pkg::FILL_W'(NB));
   assign nb_sel    = full;   // number frame starts one byte in when window is full

   // Frame checks at the decide step; window has turned 8 of 9 places,
   // so original byte j sits at slot (j + 1) mod 9.
   assign n_hdr  = nb_sel ? win_ff[2] : win_ff[1];
   assign n_lo   = nb_sel ? win_ff[8] : win_ff[7];
   assign n_hi   = nb_sel ? win_ff[0] : win_ff[8];
   assign det_ok = full && (win_ff[1] == det_hdr_ff) &&
                   (crc_d_ff[7:0] == win_ff[8]) && (crc_d_ff[15:8] == win_ff[0]);
   assign num_ok = (n_hdr == num_hdr_ff) &&
                   (crc_n_ff[7:0] == n_lo) && (crc_n_ff[15:8] == n_hi);
   assign hit    = det_ok || num_ok;

   assign det_pl = {win_ff[7], win_ff[6], win_ff[5], win_ff[4], win_ff[3], win_ff[2]};
   assign num_pl = nb_sel ? {8'h00, win_ff[7], win_ff[6], win_ff[5], win_ff[4], win_ff[3]}
                          : {8'h00, win_ff[6], win_ff[5], win_ff[4], win_ff[3], win_ff[2]};

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = ctl.check && go && hit;

   assign status.byte_beat = byte_beat;
   assign status.fill_long = (fill_ff >= crfr_pkg::FILL_W'(crfr_pkg::NUMBER_FRAME_BYTES - 1));
   assign status.hit       = hit;
   assign status.out_free  = out_free;

   // Window: push on a beat, rotate during the scan, clear on a hit
   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (byte_beat) begin
         if (!full) begin
            win_in[fill_ff[crfr_pkg::WIN_IDX_W-1:0]] = req_tdata;
            fill_in = fill_ff + crfr_pkg::FILL_W'(1);
         end else begin
            for (int i = 0; i < NB - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[NB-1] = req_tdata;
         end
      end else if (ctl.rotate && go) begin
         for (int i = 0; i < NB - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[NB-1] = win_ff[0];
      end
      if (load) begin
         for (int i = 0; i < NB; i++) begin
            win_in[i] = 8'h00;
         end
         fill_in = '0;
      end
   end

   // CRC accumulators, one byte per step from slot 0 (detect) or slot nb (number)
   assign n_tap = nb_sel ? win_ff[1] : win_ff[0];

   always_comb begin
      crc_d_in = crc_d_ff;
      crc_n_in = crc_n_ff;
      if (ctl.crc_init) begin
         crc_d_in = crfr_pkg::CRC_INIT;
         crc_n_in = crfr_pkg::CRC_INIT;
      end else begin
         if (ctl.crc_d_en) crc_d_in = crfr_pkg::crc_byte(crc_d_ff, win_ff[0]);
         if (ctl.crc_n_en) crc_n_in = crfr_pkg::crc_byte(crc_n_ff, n_tap);
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = det_ok ? crfr_pkg::KIND_DETECT : crfr_pkg::KIND_NUMBER;
         rsp_data_in  = det_ok ? det_pl : num_pl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         det_hdr_ff   <= crfr_pkg::DETECT_HEADER_RST;
         num_hdr_ff   <= crfr_pkg::NUMBER_HEADER_RST;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NB; i++) begin
            win_ff[i] <= 8'h00;
         end
      end else begin
         det_hdr_ff   <= det_hdr_in;
         num_hdr_ff   <= num_hdr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_d_ff    <= crc_d_in;
      crc_n_ff    <= crc_n_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

FILE: src/crc16_checked_frame_receiver_top.sv
// CRC-16 checked frame receiver: usage
//   req_*  : one received byte per beat in req_tdata.
//   rsp_*  : one beat per valid frame; rsp_tuser is the frame kind
//            (0 detection, 1 number), rsp_tdata the six payload bytes.
//   csr_*  : header writes, index 0 detection header, 1 number header;
//            always ready, other indexes are dropped. Write while idle.
// Byte handling: a byte that leaves fewer than eight bytes in the window
//   lets the next byte in the following cycle; any other byte starts a
//   scan of one wait step plus nine steps turning the nine-byte window once
//   past the CRC unit, one byte per step, before the next byte is taken.
// A frame's result is registered at the last of these, the decide step.
// If a result still waits on rsp_tready when the next frame is found, the
//   sequencer holds at its decide step until the output register frees;
//   req_tready stays low meanwhile.
// Reset (synchronous, active high) empties the window, drops any pending
//   result and restores headers 0xAA and 0xCC; no clearing pass is needed.
// Depends on crfr_pkg, crfr_seq, crfr_ucode_rom and crfr_datapath.
module crc16_checked_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // payload_0 [7:0] .. payload_5 [47:40]
   output logic        rsp_tuser,    // [0] frame_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   crfr_pkg::ucode_type     ctl;
   crfr_pkg::dp_status_type status;
   logic                    go;

   crfr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl),
      .go     (go)
   );

   crfr_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .go         (go),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   assign req_tready = ctl.in_ready;
   assign csr_ready  = 1'b1;

endmodule

FILE: src/crfr_checker.sv
// Port-level checks for the CRC-16 frame receiver, bound to the top level.
// Depends on crc16_checked_frame_receiver_top.
module crfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Number frames carry a zero last payload byte
   a_num_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[47:40] == 8'h00)
      else $error("number frame with nonzero payload_5");

   // A result never shows up right after a byte beat
   a_no_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result raised one cycle after a byte");

   // Reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind crc16_checked_frame_receiver_top crfr_checker u_crfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
